// ----- sv/iso_timestamp_to_epoch_seconds_core_macros.svh -----
// Assertion helpers for the timestamp core checker.
`ifndef ISO_TIMESTAMP_TO_EPOCH_SECONDS_CORE_MACROS_SVH
`define ISO_TIMESTAMP_TO_EPOCH_SECONDS_CORE_MACROS_SVH

// same-cycle implication
`define ISTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ists_pkg.sv -----
package ists_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       arg_end;
    logic       offset_follows;
  } in_word_t;

  typedef struct packed {
    logic signed [38:0] epoch_seconds;
    logic [1:0]         status;
  } out_word_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_TS  = 2'd1;
  localparam logic [1:0] STAT_BAD_OFS = 2'd2;

  // one parsed timestamp, handed from the parser to the calendar unit
  typedef struct packed {
    logic [1:0]         status;
    logic signed [14:0] year;
    logic [3:0]         mo;
    logic [4:0]         dy;
    logic signed [5:0]  hh;
    logic signed [6:0]  mi;
    logic signed [6:0]  ss;
    logic signed [5:0]  ofs_h;
    logic signed [6:0]  ofs_m;
    logic               ofs_neg;
  } job_t;

endpackage

// ----- sv/ists_front.sv -----
module ists_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  ists_pkg::in_word_t in_data,
  output logic             job_push,
  output ists_pkg::job_t   job,
  input  logic             job_full
);
  import ists_pkg::*;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef enum logic [1:0] {SEP_NONE, SEP_DASH, SEP_COLON, SEP_DT} sep_t;

  function automatic logic [7:0] sgn_mag(input logic neg, input logic [6:0] m);
    sgn_mag = neg ? 8'd0 - {1'b0, m} : {1'b0, m};
  endfunction

  logic       in_ofs_r, in_ofs_nxt;
  logic [5:0] cnt_r, cnt_nxt, cnt_inc;
  logic [13:0] yacc_r, yacc_nxt;
  logic [6:0] sacc_r [5];
  logic [6:0] sacc_nxt [5];
  logic [5:0] neg_r, neg_nxt;
  logic       err_r, err_nxt;
  logic [7:0] tw_r [5];
  logic [7:0] tw_nxt [5];

  logic       acc, emit;
  logic [7:0] c;
  logic       is_dig;
  sep_t       sep;
  logic       fld, first;
  logic [2:0] fk, fk_idx;
  logic [13:0] acc_cur, acc_ten, acc_w;

  logic       dig1, dig3, dig4, is_z, sgn_ok;
  logic signed [7:0] hv, mv;
  logic       prs_ok, loc_ok, ofs_ok, use_ofs, flds_ok;
  logic [7:0] hh8, mi8, ss8;

  assign c      = in_data.ch;
  assign acc    = push && !job_full;
  assign full   = job_full;
  assign is_dig = c inside {[CH_0:CH_9]};
  assign cnt_inc = (cnt_r == 6'd63) ? cnt_r : cnt_r + 6'd1;

  // position decode of the local part
  always_comb begin
    sep = SEP_NONE; fld = 1'b0; fk = 3'd0; first = 1'b0;
    case (cnt_r)
      6'd0: begin
        fld = 1'b1; first = 1'b1;
      end
      6'd1, 6'd2, 6'd3: fld = 1'b1;
      6'd4, 6'd7: sep = SEP_DASH;
      6'd13, 6'd16: sep = SEP_COLON;
      6'd10: sep = SEP_DT;
      6'd5: begin
        fld = 1'b1; fk = 3'd1; first = 1'b1;
      end
      6'd6: begin
        fld = 1'b1; fk = 3'd1;
      end
      6'd8: begin
        fld = 1'b1; fk = 3'd2; first = 1'b1;
      end
      6'd9: begin
        fld = 1'b1; fk = 3'd2;
      end
      6'd11: begin
        fld = 1'b1; fk = 3'd3; first = 1'b1;
      end
      6'd12: begin
        fld = 1'b1; fk = 3'd3;
      end
      6'd14: begin
        fld = 1'b1; fk = 3'd4; first = 1'b1;
      end
      6'd15: begin
        fld = 1'b1; fk = 3'd4;
      end
      6'd17: begin
        fld = 1'b1; fk = 3'd5; first = 1'b1;
      end
      6'd18: begin
        fld = 1'b1; fk = 3'd5;
      end
      default: ;
    endcase
  end

  assign fk_idx  = (fk == 3'd0) ? 3'd0 : fk - 3'd1;
  assign acc_cur = (fk == 3'd0) ? yacc_r : {7'b0, sacc_r[fk_idx]};
  assign acc_ten = acc_cur * 14'd10 + {10'b0, c[3:0]};

  always_comb begin
    in_ofs_nxt = in_ofs_r;
    cnt_nxt    = cnt_inc;
    yacc_nxt   = yacc_r;
    sacc_nxt   = sacc_r;
    neg_nxt    = neg_r;
    err_nxt    = err_r;
    acc_w      = acc_cur;
    emit       = 1'b0;
    tw_nxt[0]  = c;
    for (int i = 1; i < 5; i++) tw_nxt[i] = tw_r[i-1];

    if (!in_ofs_r) begin
      case (sep)
        SEP_DASH:  if (c != CH_MINUS) err_nxt = 1'b1;
        SEP_COLON: if (c != CH_COLON) err_nxt = 1'b1;
        SEP_DT:    if (c != CH_T && c != CH_SPACE) err_nxt = 1'b1;
        default: ;
      endcase
      if (fld) begin
        if (first && c == CH_MINUS) begin
          neg_nxt[fk] = 1'b1;
          acc_w = '0;
        end else if (is_dig) begin
          acc_w = first ? {10'b0, c[3:0]} : acc_ten;
        end else begin
          err_nxt = 1'b1;
        end
        if (fk == 3'd0) yacc_nxt = acc_w;
        else sacc_nxt[fk_idx] = acc_w[6:0];
      end
    end

    if (in_data.arg_end) begin
      if (!in_ofs_r && in_data.offset_follows) begin
        if (cnt_inc < 6'd19) err_nxt = 1'b1;
        in_ofs_nxt = 1'b1;
        cnt_nxt    = '0;
      end else begin
        emit       = 1'b1;
        in_ofs_nxt = 1'b0;
        cnt_nxt    = '0;
        yacc_nxt   = '0;
        sacc_nxt   = '{default: '0};
        neg_nxt    = '0;
        err_nxt    = 1'b0;
        tw_nxt     = '{default: '0};
      end
    end
  end

  // offset from the newest six characters: c, tw_r[0..4]
  assign dig1   = tw_r[0] inside {[CH_0:CH_9]};
  assign dig3   = tw_r[2] inside {[CH_0:CH_9]};
  assign dig4   = tw_r[3] inside {[CH_0:CH_9]};
  assign sgn_ok = (tw_r[4] == CH_PLUS) || (tw_r[4] == CH_MINUS);
  assign hv = dig4 ? {4'b0, tw_r[3][3:0]} * 8'd10 + {4'b0, tw_r[2][3:0]}
                   : 8'd0 - {4'b0, tw_r[2][3:0]};
  assign mv = dig1 ? {4'b0, tw_r[0][3:0]} * 8'd10 + {4'b0, c[3:0]}
                   : 8'd0 - {4'b0, c[3:0]};
  assign prs_ok = sgn_ok && (tw_r[1] == CH_COLON)
               && dig3 && (dig4 || tw_r[3] == CH_MINUS)
               && is_dig && (dig1 || tw_r[0] == CH_MINUS)
               && (hv <= 8'sd23) && (mv <= 8'sd59);
  assign is_z = (c == CH_UZ) || (c == CH_LZ);

  assign flds_ok = !neg_r[1] && (sacc_r[0] inside {[7'd1:7'd12]})
                && !neg_r[2] && (sacc_r[1] inside {[7'd1:7'd31]})
                && (neg_r[3] || sacc_r[2] <= 7'd23)
                && (neg_r[4] || sacc_r[3] <= 7'd59)
                && (neg_r[5] || sacc_r[4] <= 7'd59);

  assign hh8 = sgn_mag(neg_r[3], sacc_r[2]);
  assign mi8 = sgn_mag(neg_r[4], sacc_r[3]);
  assign ss8 = sgn_mag(neg_r[5], sacc_r[4]);

  always_comb begin
    loc_ok  = 1'b1;
    ofs_ok  = 1'b1;
    use_ofs = 1'b1;
    if (in_ofs_r) begin
      ofs_ok = (cnt_inc == 6'd6) && prs_ok;
    end else if (is_z) begin
      loc_ok  = cnt_inc >= 6'd20;
      use_ofs = 1'b0;
    end else if (cnt_inc < 6'd25) begin
      loc_ok = 1'b0;
    end else begin
      ofs_ok = prs_ok;
    end

    if (!loc_ok || err_r || !flds_ok) job.status = STAT_BAD_TS;
    else if (!ofs_ok)                  job.status = STAT_BAD_OFS;
    else                               job.status = STAT_OK;

    job.year    = neg_r[0] ? 15'd0 - {1'b0, yacc_r} : {1'b0, yacc_r};
    job.mo      = sacc_r[0][3:0];
    job.dy      = sacc_r[1][4:0];
    job.hh      = hh8[5:0];
    job.mi      = mi8[6:0];
    job.ss      = ss8[6:0];
    job.ofs_h   = use_ofs ? hv[5:0] : 6'd0;
    job.ofs_m   = use_ofs ? mv[6:0] : 7'd0;
    job.ofs_neg = use_ofs && (tw_r[4] == CH_MINUS);
  end

  assign job_push = acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ofs_r <= 1'b0;
      cnt_r    <= '0;
      yacc_r   <= '0;
      sacc_r   <= '{default: '0};
      neg_r    <= '0;
      err_r    <= 1'b0;
      tw_r     <= '{default: '0};
    end else if (acc) begin
      in_ofs_r <= in_ofs_nxt;
      cnt_r    <= cnt_nxt;
      yacc_r   <= yacc_nxt;
      sacc_r   <= sacc_nxt;
      neg_r    <= neg_nxt;
      err_r    <= err_nxt;
      tw_r     <= tw_nxt;
    end
  end

endmodule

// ----- sv/ists_jobq.sv -----
module ists_jobq #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ists_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output ists_pkg::job_t rd_data,
  output logic           empty
);
  import ists_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             wr_ok, rd_ok;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_ok) wptr_r <= bump(wptr_r);
      if (rd_ok) rptr_r <= bump(rptr_r);
      cnt_r <= cnt_r + CNT_W'(wr_ok) - CNT_W'(rd_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) mem_r[wptr_r] <= wr_data;
  end

endmodule

// ----- sv/ists_back.sv -----
module ists_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ists_pkg::job_t     job,
  input  logic               job_empty,
  output logic               job_pop,
  input  logic               pop,
  output logic               empty,
  output ists_pkg::out_word_t out_data
);
  import ists_pkg::*;

  localparam logic [23:0] DAYS_PER_ERA = 24'd146097;
  // three eras of year bias plus the 1970 epoch shift
  localparam logic [23:0] DAY_BIAS     = 24'd1157759;

  typedef enum logic [5:0] {
    BK_IDLE = 6'b000001,
    BK_ERA  = 6'b000010,
    BK_DOE  = 6'b000100,
    BK_DAYS = 6'b001000,
    BK_MUL  = 6'b010000,
    BK_SUM  = 6'b100000
  } bk_state_t;

  function automatic logic [8:0] month_base(input logic [3:0] mo);
    case (mo)
      4'd3:    month_base = 9'd0;
      4'd4:    month_base = 9'd31;
      4'd5:    month_base = 9'd61;
      4'd6:    month_base = 9'd92;
      4'd7:    month_base = 9'd122;
      4'd8:    month_base = 9'd153;
      4'd9:    month_base = 9'd184;
      4'd10:   month_base = 9'd214;
      4'd11:   month_base = 9'd245;
      4'd12:   month_base = 9'd275;
      4'd1:    month_base = 9'd306;
      4'd2:    month_base = 9'd337;
      default: month_base = 9'd0;
    endcase
  endfunction

  bk_state_t st_r, st_nxt;
  job_t      job_r;
  logic      ovld_r;
  out_word_t out_r;

  logic [13:0] u_r;
  logic [4:0]  q_r;
  logic [8:0]  doy_r;
  logic signed [19:0] hms_r, tod_r;
  logic [17:0] doe_r;
  logic signed [23:0] days_r;
  logic signed [39:0] prod_r;

  logic [15:0] y16, u16, qm;
  logic [4:0]  q_w;
  logic [8:0]  doy_w;
  logic signed [19:0] hms_w, ofs_w, tod_w;
  logic [13:0] q400, yoe14;
  logic [8:0]  yoe;
  logic [1:0]  c100;
  logic [17:0] doe_w;
  logic signed [23:0] days_w;
  logic signed [39:0] prod_w, secs_w;
  logic        out_we;

  // floor(y / 400) via bias of 1200 years and a reciprocal of 25
  assign y16   = {job_r.year[14], job_r.year} - {15'b0, (job_r.mo <= 4'd2)};
  assign u16   = y16 + 16'd1200;
  assign qm    = {6'b0, u16[13:4]} * 16'd41;
  assign q_w   = qm[14:10];
  assign doy_w = month_base(job_r.mo) + {4'b0, job_r.dy} - 9'd1;
  assign hms_w = job_r.hh * 13'sd3600 + job_r.mi * 8'sd60 + job_r.ss;

  assign q400  = 14'(q_r) * 14'd400;
  assign yoe14 = u_r - q400;
  assign yoe   = yoe14[8:0];
  assign c100  = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 :
                 (yoe >= 9'd100) ? 2'd1 : 2'd0;
  assign doe_w = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(c100) + 18'(doy_r);
  assign ofs_w = job_r.ofs_h * 13'sd3600 + job_r.ofs_m * 8'sd60;
  assign tod_w = job_r.ofs_neg ? hms_r + ofs_w : hms_r - ofs_w;

  assign days_w = 24'(q_r) * DAYS_PER_ERA + 24'(doe_r) - DAY_BIAS;
  assign prod_w = days_r * 18'sd86400;
  assign secs_w = prod_r + 40'(tod_r);

  assign out_we  = (st_r == BK_SUM) && (!ovld_r || pop);
  assign job_pop = (st_r == BK_IDLE) && !job_empty;
  assign empty    = !ovld_r;
  assign out_data = out_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (!job_empty) st_nxt = (job.status == STAT_OK) ? BK_ERA : BK_SUM;
      BK_ERA:  st_nxt = BK_DOE;
      BK_DOE:  st_nxt = BK_DAYS;
      BK_DAYS: st_nxt = BK_MUL;
      BK_MUL:  st_nxt = BK_SUM;
      BK_SUM:  if (out_we) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_we)   ovld_r <= 1'b1;
      else if (pop) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job;
    if (st_r == BK_ERA) begin
      u_r   <= u16[13:0];
      q_r   <= q_w;
      doy_r <= doy_w;
      hms_r <= hms_w;
    end
    if (st_r == BK_DOE) begin
      doe_r <= doe_w;
      tod_r <= tod_w;
    end
    if (st_r == BK_DAYS) days_r <= days_w;
    if (st_r == BK_MUL)  prod_r <= prod_w;
    if (out_we) begin
      out_r.epoch_seconds <= (job_r.status == STAT_OK) ? secs_w[38:0] : '0;
      out_r.status        <= job_r.status;
    end
  end

endmodule

// ----- sv/iso_timestamp_to_epoch_seconds_core.sv -----
// channel  | handshake          | word          | contents
// ---------+--------------------+---------------+------------------------------------
// input    | push / full        | in_data       | ch, arg_end, offset_follows
// result   | empty / pop        | out_data      | epoch_seconds, status
//
// The parser takes one character per cycle while full is low; full rises only
// while the job queue (JOBQ_DEPTH entries) is full. The calendar sequencer steps a
// well-formed timestamp through ERA, DOE, DAYS, MUL and SUM, sends a rejected one
// from IDLE straight to SUM, then parks the word in the output register. While that
// word waits for pop the sequencer holds its next word in SUM, and the parser stalls
// once the queue behind it fills. Reset is synchronous; there is no clearing pass.
module iso_timestamp_to_epoch_seconds_core #(
  parameter int JOBQ_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ists_pkg::in_word_t  in_data,
  output logic                empty,
  input  logic                pop,
  output ists_pkg::out_word_t out_data
);
  import ists_pkg::*;

  job_t fr_job, bk_job;
  logic fr_push, q_full, q_empty, bk_pop;

  ists_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .job_push (fr_push),
    .job      (fr_job),
    .job_full (q_full)
  );

  ists_jobq #(.DEPTH(JOBQ_DEPTH)) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_push),
    .wr_data (fr_job),
    .full    (q_full),
    .rd_en   (bk_pop),
    .rd_data (bk_job),
    .empty   (q_empty)
  );

  ists_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (bk_job),
    .job_empty (q_empty),
    .job_pop   (bk_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

// ----- sv/ists_checker.sv -----
`include "iso_timestamp_to_epoch_seconds_core_macros.svh"

module ists_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input ists_pkg::out_word_t out_data
);
  import ists_pkg::*;

  `ISTS_ASSERT_NOW(a_empty_after_rst, !$past(rst_n), empty,
                   "result pending right after reset")
  `ISTS_ASSERT_NOW(a_ready_after_rst, !$past(rst_n), !full, "full right after reset")
  `ISTS_ASSERT_NOW(a_err_zero, !empty && out_data.status != STAT_OK,
                   out_data.epoch_seconds == '0, "nonzero seconds on error")
  `ISTS_ASSERT_NEXT(a_word_holds, !empty && !pop, !empty, "result dropped without pop")
  `ISTS_ASSERT_NEXT(a_word_stable, !empty && !pop, $stable(out_data),
                    "result changed while waiting")

endmodule

bind iso_timestamp_to_epoch_seconds_core ists_checker u_ists_checker (.*);
